/* sv/ntag_pkg.sv */
package ntag_pkg;

	localparam int MAX_DIMS     = 4;
	localparam int DIM_BITS     = 16;
	localparam int SEL_BITS     = $clog2(MAX_DIMS);
	localparam int PERM_BITS    = SEL_BITS * MAX_DIMS;
	localparam int OFFSET_BITS  = 32;
	localparam int VALUE_BITS   = 64;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_BITS     = 64;
	localparam int ESZ_BITS     = 2;

	typedef logic [DIM_BITS-1:0]              dim_t;
	typedef dim_t [MAX_DIMS-1:0]              dim_vec_t;
	typedef logic [PERM_BITS-1:0]             perm_t;
	typedef logic [OFFSET_BITS-1:0]           offset_t;
	typedef logic [VALUE_BITS-1:0]            value_t;
	typedef logic [ESZ_BITS-1:0]              esz_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DIM_SIZES   = 3'd0,
		REG_PERMUTATION = 3'd1,
		REG_SRC_STRIDES = 3'd2,
		REG_DST_STRIDES = 3'd3,
		REG_ELEM_SIZE   = 3'd4
	} cfg_reg_t;

	localparam esz_t ESZ_1B = 2'd0;
	localparam esz_t ESZ_2B = 2'd1;
	localparam esz_t ESZ_4B = 2'd2;
	localparam esz_t ESZ_8B = 2'd3;

	// Counter status handed from the index counter to the datapath
	typedef struct packed {
		logic     last;
		dim_vec_t idx;
	} cnt_status_t;

	function automatic dim_vec_t ones_sizes();
		dim_vec_t r;
		for (int d = 0; d < MAX_DIMS; d++) begin
			r[d] = DIM_BITS'(1);
		end
		return r;
	endfunction

	function automatic perm_t identity_perm();
		perm_t r;
		for (int i = 0; i < MAX_DIMS; i++) begin
			r[i*SEL_BITS +: SEL_BITS] = SEL_BITS'(i);
		end
		return r;
	endfunction

	// Output dim i takes input index perm[i]; out-of-range selectors take dim 0
	function automatic dim_vec_t permute(input dim_vec_t idx, input perm_t perm);
		dim_vec_t            r;
		logic [SEL_BITS-1:0] sel;
		for (int i = 0; i < MAX_DIMS; i++) begin
			sel = perm[i*SEL_BITS +: SEL_BITS];
			if (int'(sel) < MAX_DIMS) begin
				r[i] = idx[sel];
			end else begin
				r[i] = idx[0];
			end
		end
		return r;
	endfunction

	function automatic value_t mask_value(input value_t v, input esz_t code);
		value_t r;
		case (code)
			ESZ_1B:  r = {56'd0, v[7:0]};
			ESZ_2B:  r = {48'd0, v[15:0]};
			ESZ_4B:  r = {32'd0, v[31:0]};
			default: r = v;
		endcase
		return r;
	endfunction

endpackage

/* sv/ntag_counter.sv */
module ntag_counter
	import ntag_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  dim_vec_t    sizes,
	output cnt_status_t status
);

	dim_vec_t idx_q;
	dim_vec_t idx_next;
	logic [MAX_DIMS-1:0] at_end;

	always_comb begin
		dim_t sz_m1;
		logic carry;
		carry    = 1'b1;
		idx_next = idx_q;
		for (int d = 0; d < MAX_DIMS; d++) begin
			// zero size counts as one
			sz_m1     = (sizes[d] == '0) ? '0 : sizes[d] - DIM_BITS'(1);
			at_end[d] = (idx_q[d] >= sz_m1);
		end
		// fastest dimension is the highest one: ripple carry downward
		for (int d = MAX_DIMS - 1; d >= 0; d--) begin
			if (carry) begin
				if (at_end[d]) begin
					idx_next[d] = '0;
				end else begin
					idx_next[d] = idx_q[d] + DIM_BITS'(1);
					carry       = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (advance) begin
			idx_q <= idx_next;
		end
	end

	assign status.idx  = idx_q;
	assign status.last = &at_end;

endmodule

/* sv/ntag_dot.sv */
module ntag_dot
	import ntag_pkg::*;
(
	input  dim_vec_t idx,
	input  dim_vec_t strides,
	output offset_t  offset
);

	always_comb begin
		offset = '0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			offset = offset + (OFFSET_BITS'(idx[d]) * OFFSET_BITS'(strides[d]));
		end
	end

endmodule

/* sv/nd_transpose_address_gen_core.sv */
// An accepted request is captured in stage one, then in the output register on the master side.
// Throughput: one request per cycle; stage one holds only while the output register is full
// and m_tready is low, so the input side stalls only when stage one is also full.
// Each offset takes four 16x16 multiplies and a chain of adds in stage two.
// Reset (arst_n low, asynchronous): pipeline emptied, index counter zero, registers to
// sizes of one, identity permutation, zero strides, one-byte elements.
module nd_transpose_address_gen_core
	import ntag_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write port
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	// input stream
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [63:0]             s_tdata,   // [63:0] elem_value
	// result stream
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [127:0]            m_tdata,   // [31:0] src_offset, [63:32] dst_offset,
	                                           // [127:64] out_value
	output logic                    m_tlast    // is_last
);

	// Configuration registers
	dim_vec_t sizes_q;
	perm_t    perm_q;
	dim_vec_t src_strides_q;
	dim_vec_t dst_strides_q;
	esz_t     esz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sizes_q       <= ones_sizes();
			perm_q        <= identity_perm();
			src_strides_q <= '0;
			dst_strides_q <= '0;
			esz_q         <= ESZ_1B;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIM_SIZES:   sizes_q       <= cfg_data;
				REG_PERMUTATION: perm_q        <= cfg_data[PERM_BITS-1:0];
				REG_SRC_STRIDES: src_strides_q <= cfg_data;
				REG_DST_STRIDES: dst_strides_q <= cfg_data;
				REG_ELEM_SIZE:   esz_q         <= cfg_data[ESZ_BITS-1:0];
				default: ;  // drop writes to unknown indexes
			endcase
		end
	end

	// Pipeline handshake: stage two is the output register, stage one holds the
	// index snapshot. Each stage loads when it is empty or its content moves on.
	logic     valid_s1;
	logic     valid_s2;
	logic     load_s1;
	logic     load_s2;

	assign load_s2  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || load_s2;
	assign load_s1  = s_tvalid && s_tready;

	// Index counter: advance once per accepted request
	cnt_status_t cnt;

	ntag_counter u_counter (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(load_s1),
		.sizes  (sizes_q),
		.status (cnt)
	);

	// Stage one: capture the index the element belongs to, plus its value
	dim_vec_t idx_s1;
	value_t   value_s1;
	logic     last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			idx_s1   <= cnt.idx;
			value_s1 <= s_tdata;
			last_s1  <= cnt.last;
		end
	end

	// Stage two: offsets and value mask, straight into the output register
	offset_t src_off;
	offset_t dst_off;

	ntag_dot u_src_dot (
		.idx    (idx_s1),
		.strides(src_strides_q),
		.offset (src_off)
	);

	ntag_dot u_dst_dot (
		.idx    (permute(idx_s1, perm_q)),
		.strides(dst_strides_q),
		.offset (dst_off)
	);

	offset_t src_s2;
	offset_t dst_s2;
	value_t  value_s2;
	logic    last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			src_s2   <= src_off;
			dst_s2   <= dst_off;
			value_s2 <= mask_value(value_s1, esz_q);
			last_s2  <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {value_s2, dst_s2, src_s2};
	assign m_tlast  = last_s2;

	// The counter wraps to zero after the last element of the tensor
	a_wrap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s1 && cnt.last) |=> (cnt.idx == '0))
		else $error("index counter did not wrap after last element");

	// An empty first stage never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty stage one");

	// An accepted request occupies stage one on the next cycle
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 |=> valid_s1)
		else $error("accepted request lost before stage one");

	// The counter only moves when a request is accepted
	a_counter_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!load_s1 |=> $stable(cnt.idx))
		else $error("index counter moved without a request");

endmodule
